[rtl/cwd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cwd_pkg;

  localparam int CWD_MAX_WORDS = 16;
  localparam int CWD_CFG_W     = 5;
  localparam int CWD_BYTE_W    = 8;
  localparam int CWD_WORD_W    = 16;
  localparam int CWD_IDX_W     = 4;

  localparam logic [7:0] CWD_CRC_POLY = 8'h31;
  localparam logic [7:0] CWD_CRC_INIT = 8'hFF;
  localparam logic [CWD_CFG_W-1:0] CWD_WPR_RESET = CWD_CFG_W'(1);

  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_CRC  = 2'd2
  } cwd_phase_t;

  typedef struct packed {
    logic [CWD_BYTE_W-1:0] rx_byte;
    logic                  start_req;
  } cwd_item_t;

  // One byte through the CRC-8 shift network, MSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CWD_CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/crc_checked_word_deframer_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Splits a received read transfer into big-endian 16-bit words, each followed by
// a CRC-8 byte (polynomial 0x31, init 0xFF), and returns one transaction per word
// with its index, the computed CRC and a mismatch flag. A byte with in_tuser set
// starts a transfer; the word marked tlast is the final one of words_per_read or
// the first mismatch, and later bytes are dropped until the next start byte. One
// byte is taken every cycle: an input register feeds a single pass of framing and
// CRC logic into the output register, and the input stalls only while a result
// waits in that output register and out_tready is low. A result is registered in
// the output register when its CRC byte is taken from the input register.

module crc_checked_word_deframer_top
  import cwd_pkg::*;
#(
  parameter int MAX_WORDS = CWD_MAX_WORDS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CWD_CFG_W-1:0] cfg_data,   // words_per_read
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] rx_byte
  input  wire logic                 in_tuser,   // start_req
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [31:0]               out_tdata,  // [15:0] word_value, [19:16] word_index,
                                                // [27:20] calc_crc, [31:28] zero
  output logic                      out_tuser,  // crc_error
  output logic                      out_tlast
);

  logic [CWD_CFG_W-1:0]  wpr_r;
  cwd_item_t             in_item;
  cwd_item_t             s1_item;
  logic                  s1_valid;
  logic                  s1_take;
  logic [CWD_WORD_W-1:0] word_value;
  logic [CWD_IDX_W-1:0]  word_index;
  logic [7:0]            calc_crc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpr_r <= CWD_WPR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      wpr_r <= cfg_data;
    end
  end

  assign in_item.rx_byte   = in_tdata;
  assign in_item.start_req = in_tuser;

  cwd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_take  (s1_take)
  );

  cwd_deframe #(
    .MAX_WORDS (MAX_WORDS)
  ) u_deframe (
    .clk            (clk),
    .rst_n          (rst_n),
    .words_per_read (wpr_r),
    .s1_valid       (s1_valid),
    .s1_item        (s1_item),
    .s1_take        (s1_take),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .word_value     (word_value),
    .word_index     (word_index),
    .crc_error      (out_tuser),
    .calc_crc       (calc_crc),
    .last           (out_tlast)
  );

  assign out_tdata = {4'b0000, calc_crc, word_index, word_value};

endmodule

`default_nettype wire

[rtl/cwd_in_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module cwd_in_reg
  import cwd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire cwd_item_t in_item,
  output logic           s1_valid,
  output cwd_item_t      s1_item,
  input  wire logic      s1_take
);

  logic      valid_r;
  logic      valid_nxt;
  cwd_item_t item_r;

  assign in_ready  = !valid_r || s1_take;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (s1_take ? 1'b0 : valid_r);
  assign s1_valid  = valid_r;
  assign s1_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

[rtl/cwd_deframe.sv]
`timescale 1ns / 1ps
`default_nettype none

module cwd_deframe
  import cwd_pkg::*;
#(
  parameter int MAX_WORDS = CWD_MAX_WORDS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [CWD_CFG_W-1:0]  words_per_read,
  input  wire logic                  s1_valid,
  input  wire cwd_item_t             s1_item,
  output logic                       s1_take,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [CWD_WORD_W-1:0]      word_value,
  output logic [CWD_IDX_W-1:0]       word_index,
  output logic                       crc_error,
  output logic [7:0]                 calc_crc,
  output logic                       last
);

  localparam int CNT_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CMP_W = 8;

  cwd_phase_t                phase_r, phase_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      aborted_r, aborted_nxt;
  logic [7:0]                crc_r, crc_nxt;
  logic [CWD_WORD_W-1:0]     word_r, word_nxt;

  logic                      out_valid_r;
  logic [CWD_WORD_W-1:0]     out_word_r;
  logic [CWD_IDX_W-1:0]      out_idx_r;
  logic                      out_err_r;
  logic [7:0]                out_crc_r;
  logic                      out_last_r;

  cwd_phase_t                phase_eff;
  logic [CNT_W-1:0]          cnt_eff;
  logic                      aborted_eff;
  logic                      emit;
  logic                      err;
  logic                      is_last;
  logic [CMP_W-1:0]          eff_count;
  logic [CMP_W-1:0]          cnt_plus1;
  logic [CNT_W+CWD_IDX_W-1:0] cnt_ext;

  assign s1_take = s1_valid && (!out_valid_r || out_ready);

  always_comb begin
    eff_count = CMP_W'(words_per_read);
    if (eff_count == '0) begin
      eff_count = CMP_W'(1);
    end
    if (eff_count > CMP_W'(MAX_WORDS)) begin
      eff_count = CMP_W'(MAX_WORDS);
    end
  end

  always_comb begin
    phase_eff   = s1_item.start_req ? PH_HIGH : phase_r;
    cnt_eff     = s1_item.start_req ? '0 : cnt_r;
    aborted_eff = s1_item.start_req ? 1'b0 : aborted_r;
    cnt_plus1   = CMP_W'(cnt_eff) + CMP_W'(1);
    cnt_ext     = {{CWD_IDX_W{1'b0}}, cnt_eff};
    err         = (crc_r != s1_item.rx_byte);
    is_last     = err || (cnt_plus1 >= eff_count);

    phase_nxt   = phase_eff;
    cnt_nxt     = cnt_eff;
    aborted_nxt = aborted_eff;
    crc_nxt     = crc_r;
    word_nxt    = word_r;
    emit        = 1'b0;

    if (!aborted_eff) begin
      case (phase_eff)
        PH_LOW: begin
          word_nxt  = {word_r[CWD_WORD_W-1:CWD_BYTE_W], s1_item.rx_byte};
          crc_nxt   = crc8_byte(crc_r, s1_item.rx_byte);
          phase_nxt = PH_CRC;
        end
        PH_CRC: begin
          emit      = 1'b1;
          phase_nxt = PH_HIGH;
          if (is_last) begin
            aborted_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_eff + CNT_W'(1);
          end
        end
        default: begin
          word_nxt  = {s1_item.rx_byte, word_r[CWD_BYTE_W-1:0]};
          crc_nxt   = crc8_byte(CWD_CRC_INIT, s1_item.rx_byte);
          phase_nxt = PH_LOW;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HIGH;
      cnt_r       <= '0;
      aborted_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_take) begin
        phase_r   <= phase_nxt;
        cnt_r     <= cnt_nxt;
        aborted_r <= aborted_nxt;
      end
      if (s1_take && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      crc_r  <= crc_nxt;
      word_r <= word_nxt;
    end
    if (s1_take && emit) begin
      out_word_r <= word_r;
      out_idx_r  <= cnt_ext[CWD_IDX_W-1:0];
      out_err_r  <= err;
      out_crc_r  <= crc_r;
      out_last_r <= is_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign word_value   = out_word_r;
  assign word_index   = out_idx_r;
  assign crc_error    = out_err_r;
  assign calc_crc     = out_crc_r;
  assign last         = out_last_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(cnt_r) < CMP_W'(MAX_WORDS))
    else $error("word counter beyond the maximum word count");

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_last_r)
    else $error("CRC mismatch result not marked last");

  a_last_aborts: assert property (@(posedge clk) disable iff (!rst_n)
    s1_take && emit && is_last |=> aborted_r)
    else $error("block not idle after the final word");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_take && !s1_item.start_req && aborted_r |=> $stable(cnt_r) && aborted_r)
    else $error("state changed on a byte while idle");
`endif

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import cwd_pkg::*;

  typedef struct packed {
    logic [15:0] value;
    logic [3:0]  index;
    logic        crc_err;
    logic [7:0]  crc;
    logic        last;
  } word_rec_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_GOOD_CRC,
    ROW_TYPED
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] rx;
    logic       start;
    logic       has_word;
    word_rec_t  word;
  } dir_row_t;

  localparam int DIR_N      = 24;
  localparam int RAND_ITEMS = 1350;
  localparam int PHASE_LEN  = 150;
  localparam int SWEEP_N    = 6;

  localparam logic [CWD_CFG_W-1:0] CFG_SWEEP [SWEEP_N] = '{
    5'd0, 5'd31, 5'd16, 5'd1, 5'd17, 5'd3
  };

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{ROW_TYPED,    8'h12, 1'b0, 1'b0, '0},
    '{ROW_TYPED,    8'hBE, 1'b1, 1'b0, '0},
    '{ROW_TYPED,    8'hEF, 1'b0, 1'b0, '0},
    '{ROW_TYPED,    8'h92, 1'b0, 1'b1, '{16'hBEEF, 4'd0, 1'b0, 8'h92, 1'b1}},
    '{ROW_TYPED,    8'h55, 1'b0, 1'b0, '0},
    '{ROW_TYPED,    8'hBE, 1'b1, 1'b0, '0},
    '{ROW_TYPED,    8'hEF, 1'b0, 1'b0, '0},
    '{ROW_TYPED,    8'h6D, 1'b0, 1'b1, '{16'hBEEF, 4'd0, 1'b1, 8'h92, 1'b1}},
    '{ROW_TYPED,    8'h00, 1'b0, 1'b0, '0},
    '{ROW_PREDICT,  8'hFF, 1'b1, 1'b0, '0},
    '{ROW_PREDICT,  8'hFF, 1'b0, 1'b0, '0},
    '{ROW_GOOD_CRC, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_PREDICT,  8'h00, 1'b1, 1'b0, '0},
    '{ROW_PREDICT,  8'h00, 1'b0, 1'b0, '0},
    '{ROW_PREDICT,  8'hFF, 1'b0, 1'b0, '0},
    '{ROW_PREDICT,  8'h11, 1'b1, 1'b0, '0},
    '{ROW_PREDICT,  8'h22, 1'b0, 1'b0, '0},
    '{ROW_PREDICT,  8'h33, 1'b1, 1'b0, '0},
    '{ROW_PREDICT,  8'h44, 1'b0, 1'b0, '0},
    '{ROW_GOOD_CRC, 8'h00, 1'b0, 1'b0, '0},
    '{ROW_PREDICT,  8'h66, 1'b1, 1'b0, '0},
    '{ROW_PREDICT,  8'h77, 1'b1, 1'b0, '0},
    '{ROW_PREDICT,  8'h88, 1'b0, 1'b0, '0},
    '{ROW_GOOD_CRC, 8'h00, 1'b0, 1'b0, '0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CWD_CFG_W-1:0] cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [31:0]          out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;

  logic [CWD_CFG_W-1:0] wpr_reg;
  cwd_phase_t           ph;
  logic [7:0]           hi_q;
  logic [7:0]           lo_q;
  int                   word_cnt;
  bit                   idle_q;
  word_rec_t            pending_words[$];

  bit tx_burst;
  int err_count;
  int bytes_sent;
  int words_checked;
  int crc_flags;
  int cfg_writes;

  always #6 clk = ~clk;

  crc_checked_word_deframer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      if (c[7] ^ data[i]) begin
        c = {c[6:0], 1'b0} ^ CWD_CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] word_crc(input logic [7:0] h, input logic [7:0] l);
    return crc8_update(crc8_update(CWD_CRC_INIT, h), l);
  endfunction

  function automatic int eff_words();
    if (wpr_reg == 0) begin
      return 1;
    end
    if (wpr_reg > CWD_MAX_WORDS) begin
      return CWD_MAX_WORDS;
    end
    return int'(wpr_reg);
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, input logic s, output word_rec_t w);
    w = '0;
    if (s) begin
      ph = PH_HIGH;
      word_cnt = 0;
      idle_q = 1'b0;
    end
    if (idle_q) begin
      return 1'b0;
    end
    if (ph == PH_LOW) begin
      lo_q = b;
      ph = PH_CRC;
      return 1'b0;
    end
    if (ph != PH_CRC) begin
      hi_q = b;
      ph = PH_LOW;
      return 1'b0;
    end
    w.value   = {hi_q, lo_q};
    w.index   = word_cnt[3:0];
    w.crc     = word_crc(hi_q, lo_q);
    w.crc_err = (w.crc != b);
    w.last    = w.crc_err || (word_cnt + 1 >= eff_words());
    ph = PH_HIGH;
    if (w.last) begin
      idle_q = 1'b1;
    end else begin
      word_cnt++;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      err_count++;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic s);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= s;
    do begin
      @(posedge clk);
    end while (in_tready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic feed(input logic [7:0] b, input logic s);
    word_rec_t w;
    send_byte(b, s);
    if (deframe_byte(b, s, w)) begin
      pending_words.push_back(w);
    end
  endtask

  task automatic write_cfg(input logic [CWD_CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(posedge clk);
    end while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    wpr_reg = v;
    cfg_writes++;
  endtask

  task automatic drain();
    int guard;
    in_tvalid <= 1'b0;
    guard = 0;
    while (pending_words.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);
  endtask

  // Mostly complete transfers with random words, plus cut-off transfers, line noise
  // and words that arrive without a start byte.
  task automatic play_transfer();
    int kind;
    int n;
    int words;
    logic first;
    logic [7:0] h;
    logic [7:0] l;
    logic [7:0] c;
    if ($urandom_range(0, 5) == 0) begin
      tx_burst = !tx_burst;
    end
    kind = $urandom_range(0, 9);
    n = eff_words();
    first = (kind != 9);
    if (kind == 8) begin
      repeat ($urandom_range(1, 8)) feed(8'($urandom), ($urandom_range(0, 7) == 0));
    end else begin
      if (kind <= 6) begin
        words = ($urandom_range(0, 4) != 0) ? n : $urandom_range(1, n + 2);
      end else if (kind == 7) begin
        words = $urandom_range(0, n - 1);
      end else begin
        words = $urandom_range(1, 3);
      end
      for (int k = 0; k < words; k++) begin
        h = 8'($urandom);
        l = 8'($urandom);
        c = word_crc(h, l);
        if ($urandom_range(0, 11) == 0) begin
          c = c ^ 8'($urandom_range(1, 255));
        end
        feed(h, first);
        first = 1'b0;
        feed(l, 1'b0);
        feed(c, 1'b0);
      end
      if (kind == 7) begin
        feed(8'($urandom), first);
        if ($urandom_range(0, 1) == 1) begin
          feed(8'($urandom), 1'b0);
        end
      end else if (kind <= 6 && $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) feed(8'($urandom), 1'b0);
      end
    end
  endtask

  initial begin
    dir_row_t   row;
    word_rec_t  w;
    logic [7:0] rx;
    int         phase_no;
    int         target;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    wpr_reg  = CWD_WPR_RESET;
    ph       = PH_HIGH;
    hi_q     = '0;
    lo_q     = '0;
    word_cnt = 0;
    idle_q   = 1'b1;
    tx_burst = 1'b0;
    phase_no = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_N; r++) begin
      row = DIR_ROWS[r];
      rx = (row.kind == ROW_GOOD_CRC) ? word_crc(hi_q, lo_q) : row.rx;
      send_byte(rx, row.start);
      if (row.kind == ROW_TYPED) begin
        void'(deframe_byte(rx, row.start, w));
        if (row.has_word) begin
          pending_words.push_back(row.word);
        end
      end else if (deframe_byte(rx, row.start, w)) begin
        pending_words.push_back(w);
      end
    end
    drain();

    while (bytes_sent < DIR_N + RAND_ITEMS) begin
      if (phase_no < SWEEP_N) begin
        write_cfg(CFG_SWEEP[phase_no]);
      end else begin
        write_cfg(CWD_CFG_W'($urandom_range(0, 31)));
      end
      phase_no++;
      target = bytes_sent + PHASE_LEN;
      if (target > DIR_N + RAND_ITEMS) begin
        target = DIR_N + RAND_ITEMS;
      end
      while (bytes_sent < target) begin
        play_transfer();
      end
      drain();
    end

    if (pending_words.size() != 0) begin
      $error("%0d words never arrived", pending_words.size());
      err_count++;
    end
    $display("Sent %0d bytes over %0d word-count settings.", bytes_sent, cfg_writes);
    $display("Checked %0d words, %0d of them flagged with a CRC mismatch.",
             words_checked, crc_flags);
    if (err_count == 0) begin
      $display("crc_checked_word_deframer_top regression: pass");
    end else begin
      $display("crc_checked_word_deframer_top regression: fail");
    end
    $finish;
  end

  initial begin : result_sink
    word_rec_t got_w;
    word_rec_t exp_w;
    int        stall;
    bit        rx_burst;
    out_tready <= 1'b0;
    stall    = 0;
    rx_burst = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
        got_w = '{out_tdata[15:0], out_tdata[19:16], out_tuser, out_tdata[27:20], out_tlast};
        if (pending_words.size() == 0) begin
          $error("unexpected transaction: word_value %h, word_index %0d",
                 got_w.value, got_w.index);
          err_count++;
        end else begin
          exp_w = pending_words.pop_front();
          check_field("word_value", exp_w.value, got_w.value);
          check_field("word_index", 16'(exp_w.index), 16'(got_w.index));
          check_field("crc_error", 16'(exp_w.crc_err), 16'(got_w.crc_err));
          check_field("calc_crc", 16'(exp_w.crc), 16'(got_w.crc));
          check_field("last", 16'(exp_w.last), 16'(got_w.last));
          words_checked++;
          if (exp_w.crc_err) begin
            crc_flags++;
          end
        end
        if ($urandom_range(0, 15) == 0) begin
          rx_burst = !rx_burst;
        end
        stall = rx_burst ? 0 : $urandom_range(0, 7);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("crc_checked_word_deframer_top regression: fail");
    $finish;
  end

endmodule
